/* rtl/nec_ir_frame_decoder_top_defines.svh */
// Assertion macros for the NEC IR frame decoder checker.
// Depends on nothing; included by the checker file only.
`ifndef NEC_IR_FRAME_DECODER_TOP_DEFINES_SVH
`define NEC_IR_FRAME_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define NIFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nifd assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define NIFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nifd assertion failed");

`endif

/* rtl/nifd_pkg.sv */
// Shared types and constants for the NEC IR frame decoder.
// No dependencies; imported by the front, queue, back and top modules.
`default_nettype none

package nifd_pkg;

  localparam int unsigned NUM_WIN   = 5;
  localparam int unsigned WIN_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned TICK_W    = 16;

  // Register indexes of the window registers
  localparam logic [CFG_IDX_W-1:0] REG_LEADER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 3'd4;

  // Window reset values
  localparam logic [WIN_W-1:0] RST_LEADER = 32'd655368000;
  localparam logic [WIN_W-1:0] RST_FRAME  = 32'd327684000;
  localparam logic [WIN_W-1:0] RST_REPEAT = 32'd170395500;
  localparam logic [WIN_W-1:0] RST_ONE    = 32'd124519800;
  localparam logic [WIN_W-1:0] RST_SHORT  = 32'd52429100;

  // Data phase: number of edges that make up one byte
  localparam logic [4:0] EDGES_PER_BYTE = 5'd16;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEADER = 3'd1,
    PH_SPACE  = 3'd2,
    PH_DATA   = 3'd3,
    PH_END    = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    EV_IDLE    = 3'd0,
    EV_LEADER  = 3'd1,
    EV_FRAME   = 3'd2,
    EV_REPEAT  = 3'd3,
    EV_LONG    = 3'd4,
    EV_SHORT   = 3'd5,
    EV_UNKNOWN = 3'd6
  } event_e;

  typedef enum logic {
    OP_EDGE    = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef struct packed {
    logic [WIN_W-1:0] leader;
    logic [WIN_W-1:0] frame;
    logic [WIN_W-1:0] rpt;
    logic [WIN_W-1:0] one;
    logic [WIN_W-1:0] short_w;
  } windows_t;

  // Classified item passed from front to back
  typedef struct packed {
    op_e    op;
    event_e ev;
  } item_t;

  // Queue handshake between front, queue and back
  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

endpackage

`default_nettype wire

/* rtl/nifd_if.sv */
// Stream interfaces for the NEC IR frame decoder input and result channels.
// Standalone; used by the top level and the front and back modules.
`default_nettype none

interface nifd_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] interval;

  modport source (output valid, output operation, output interval, input ready);
  modport sink   (input valid, input operation, input interval, output ready);
endinterface

interface nifd_out_if;
  logic       valid;
  logic       ready;
  logic       frame_ready;
  logic [7:0] address_byte;
  logic [7:0] command_byte;
  logic       is_repeat;
  logic       fault;
  logic [2:0] fault_state;
  logic [2:0] fault_event;

  modport source (output valid, output frame_ready, output address_byte,
                  output command_byte, output is_repeat, output fault,
                  output fault_state, output fault_event, input ready);
  modport sink   (input valid, input frame_ready, input address_byte,
                  input command_byte, input is_repeat, input fault,
                  input fault_state, input fault_event, output ready);
endinterface

`default_nettype wire

/* rtl/nifd_front.sv */
// Front end: accepts input items and sorts the interval into a window class.
// Depends on nifd_pkg and nifd_in_if.
`default_nettype none

module nifd_front
  import nifd_pkg::*;
(
  nifd_in_if.sink    in_s,
  input  windows_t   win_i,
  input  logic       q_ready_i,
  output push_t      push_o
);

  function automatic logic in_win(logic [WIN_W-1:0] w, logic [TICK_W-1:0] t);
    return (t >= w[TICK_W-1:0]) && (t <= w[WIN_W-1:TICK_W]);
  endfunction

  event_e ev;

  // Sort into the first matching window, in priority order
  always_comb begin
    priority if (in_win(win_i.leader, in_s.interval)) begin
      ev = EV_LEADER;
    end else if (in_win(win_i.frame, in_s.interval)) begin
      ev = EV_FRAME;
    end else if (in_win(win_i.rpt, in_s.interval)) begin
      ev = EV_REPEAT;
    end else if (in_win(win_i.one, in_s.interval)) begin
      ev = EV_LONG;
    end else if (in_win(win_i.short_w, in_s.interval)) begin
      ev = EV_SHORT;
    end else begin
      ev = EV_UNKNOWN;
    end
  end

  assign in_s.ready      = q_ready_i;
  assign push_o.valid    = in_s.valid & q_ready_i;
  assign push_o.item.op  = op_e'(in_s.operation);
  assign push_o.item.ev  = ev;

endmodule

`default_nettype wire

/* rtl/nifd_queue.sv */
// Short queue of classified items between front and back.
// Depends on nifd_pkg.
`default_nettype none

module nifd_queue
  import nifd_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  output logic   ready_o,
  output push_t  head_o,
  input  logic   pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_pop;

  assign ready_o     = (cnt_q != FULL);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];
  assign do_pop       = pop_i & head_o.valid;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i.valid, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

endmodule

`default_nettype wire

/* rtl/nifd_back.sv */
// Back end: runs the frame state machine and registers one result per item.
// Depends on nifd_pkg and nifd_out_if.
`default_nettype none

module nifd_back
  import nifd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  push_t       head_i,
  output logic        pop_o,
  nifd_out_if.source  out_s
);

  phase_e      phase_q, phase_d;
  logic        ready_q, ready_d;
  logic        repeat_q, repeat_d;
  logic [7:0]  addr_q, addr_d, cmd_q, cmd_d;
  logic [7:0]  prior_addr_q, prior_addr_d, prior_cmd_q, prior_cmd_d;
  logic [4:0]  ecnt_q, ecnt_d;
  logic [7:0]  shift_q, shift_d;
  logic        inv_q, inv_d;
  logic        on_cmd_q, on_cmd_d;

  logic        fault;
  phase_e      fault_ph;
  event_e      fault_ev;
  event_e      ev;
  logic [4:0]  ecnt_inc;
  logic [7:0]  shifted, held;
  logic        bit_ok;

  // Output register
  logic        ovalid_q;
  logic        o_ready_q, o_repeat_q, o_fault_q;
  logic [7:0]  o_addr_q, o_cmd_q;
  logic [2:0]  o_fst_q, o_fev_q;

  assign pop_o = head_i.valid & (~ovalid_q | out_s.ready);

  assign ev       = (phase_q == PH_IDLE) ? EV_IDLE : head_i.item.ev;
  assign ecnt_inc = ecnt_q + 1'b1;
  assign shifted  = {shift_q[6:0], (ev == EV_LONG)};
  assign bit_ok   = (ev == EV_LONG) || (ev == EV_SHORT);
  assign held     = on_cmd_q ? cmd_q : addr_q;

  // Next state of the frame machine for the item at the queue head
  always_comb begin
    phase_d      = phase_q;
    ready_d      = ready_q;
    repeat_d     = repeat_q;
    addr_d       = addr_q;
    cmd_d        = cmd_q;
    prior_addr_d = prior_addr_q;
    prior_cmd_d  = prior_cmd_q;
    ecnt_d       = ecnt_q;
    shift_d      = shift_q;
    inv_d        = inv_q;
    on_cmd_d     = on_cmd_q;
    fault        = 1'b0;
    fault_ph     = PH_IDLE;
    fault_ev     = EV_IDLE;

    if (head_i.item.op == OP_RELEASE) begin
      fault = 1'b0;
    end else if (ready_q) begin
      fault = 1'b0;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          phase_d = PH_LEADER;
        end
        PH_LEADER: begin
          if (ev == EV_LEADER) phase_d = PH_SPACE;
          else                 fault   = 1'b1;
        end
        PH_SPACE: begin
          if (ev == EV_FRAME) begin
            phase_d  = PH_DATA;
            on_cmd_d = 1'b0;
            inv_d    = 1'b0;
            ecnt_d   = '0;
            shift_d  = '0;
          end else if (ev == EV_REPEAT) begin
            phase_d  = PH_END;
            addr_d   = prior_addr_q;
            cmd_d    = prior_cmd_q;
            repeat_d = 1'b1;
          end else begin
            fault = 1'b1;
          end
        end
        PH_DATA: begin
          ecnt_d = ecnt_inc;
          if (ecnt_inc >= EDGES_PER_BYTE) begin
            // Eighth bit: store the byte or check it against its inverse
            if (!bit_ok) begin
              fault = 1'b1;
            end else if (!inv_q) begin
              inv_d = 1'b1;
              if (on_cmd_q) cmd_d  = shifted;
              else          addr_d = shifted;
            end else if ((held & shifted) == 8'h00) begin
              inv_d = 1'b0;
              if (!on_cmd_q) on_cmd_d = 1'b1;
              else           phase_d  = PH_END;
            end else begin
              fault = 1'b1;
            end
            ecnt_d  = '0;
            shift_d = '0;
          end else if (!ecnt_inc[0]) begin
            shift_d = shifted;
            if (!bit_ok) fault = 1'b1;
          end
        end
        PH_END: begin
          if (ev == EV_SHORT) ready_d = 1'b1;
          else                fault   = 1'b1;
        end
        default: begin
          fault = 1'b1;
        end
      endcase
    end

    if (fault) begin
      fault_ph = phase_q;
      fault_ev = ev;
    end

    // Restart on release or on a protocol error
    if ((head_i.item.op == OP_RELEASE) || fault) begin
      phase_d      = PH_IDLE;
      ready_d      = 1'b0;
      repeat_d     = 1'b0;
      prior_addr_d = addr_q;
      prior_cmd_d  = cmd_q;
      addr_d       = '0;
      cmd_d        = '0;
    end
  end

  // Frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      ready_q      <= 1'b0;
      repeat_q     <= 1'b0;
      addr_q       <= '0;
      cmd_q        <= '0;
      prior_addr_q <= '0;
      prior_cmd_q  <= '0;
      ecnt_q       <= '0;
      shift_q      <= '0;
      inv_q        <= 1'b0;
      on_cmd_q     <= 1'b0;
    end else if (pop_o) begin
      phase_q      <= phase_d;
      ready_q      <= ready_d;
      repeat_q     <= repeat_d;
      addr_q       <= addr_d;
      cmd_q        <= cmd_d;
      prior_addr_q <= prior_addr_d;
      prior_cmd_q  <= prior_cmd_d;
      ecnt_q       <= ecnt_d;
      shift_q      <= shift_d;
      inv_q        <= inv_d;
      on_cmd_q     <= on_cmd_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (pop_o) begin
      ovalid_q <= 1'b1;
    end else if (out_s.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      o_ready_q  <= ready_d;
      o_addr_q   <= addr_d;
      o_cmd_q    <= cmd_d;
      o_repeat_q <= repeat_d;
      o_fault_q  <= fault;
      o_fst_q    <= fault_ph;
      o_fev_q    <= fault_ev;
    end
  end

  assign out_s.valid        = ovalid_q;
  assign out_s.frame_ready  = o_ready_q;
  assign out_s.address_byte = o_addr_q;
  assign out_s.command_byte = o_cmd_q;
  assign out_s.is_repeat    = o_repeat_q;
  assign out_s.fault        = o_fault_q;
  assign out_s.fault_state  = o_fst_q;
  assign out_s.fault_event  = o_fev_q;

endmodule

`default_nettype wire

/* rtl/nec_ir_frame_decoder_top.sv */
// NEC IR frame decoder: one result per input item, accepted one per cycle
// while the queue has room. The queue stores the item at acceptance and the
// output register takes its result when the back end pops it from the queue.
// Throughput: one item per cycle while the result side keeps taking results.
// Reset: async active low; windows take defaults; frame state, queue pointers, output valid clear.
// Depends on nifd_pkg, nifd_if, nifd_front, nifd_queue, nifd_back.
`default_nettype none

module nec_ir_frame_decoder_top
  import nifd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [WIN_W-1:0]      cfg_wdata_i,
  nifd_in_if.sink               in_i,
  nifd_out_if.source            out_o
);

  windows_t win_q;
  push_t    push;
  push_t    head;
  logic     q_ready;
  logic     pop;

  // Window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.leader  <= RST_LEADER;
      win_q.frame   <= RST_FRAME;
      win_q.rpt     <= RST_REPEAT;
      win_q.one     <= RST_ONE;
      win_q.short_w <= RST_SHORT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEADER: win_q.leader  <= cfg_wdata_i;
        REG_FRAME:  win_q.frame   <= cfg_wdata_i;
        REG_REPEAT: win_q.rpt     <= cfg_wdata_i;
        REG_ONE:    win_q.one     <= cfg_wdata_i;
        REG_SHORT:  win_q.short_w <= cfg_wdata_i;
        default:    win_q         <= win_q;
      endcase
    end
  end

  nifd_front u_front (
    .in_s      (in_i),
    .win_i     (win_q),
    .q_ready_i (q_ready),
    .push_o    (push)
  );

  nifd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .head_o  (head),
    .pop_i   (pop)
  );

  nifd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_s  (out_o)
  );

endmodule

`default_nettype wire

/* rtl/nifd_checker.sv */
// Port-level checks for the NEC IR frame decoder, bound to the top level.
// Depends on nec_ir_frame_decoder_top_defines.svh and the top level ports.
`default_nettype none

`include "nec_ir_frame_decoder_top_defines.svh"

module nifd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       frame_ready_i,
  input logic [7:0] address_byte_i,
  input logic [7:0] command_byte_i,
  input logic       is_repeat_i,
  input logic       fault_i,
  input logic [2:0] fault_state_i,
  input logic [2:0] fault_event_i
);

  // A fault comes from a busy phase and a non-idle event code, unknown included
  `NIFD_ASSERT_NOW(a_fault_codes, clk_i, rst_ni, out_valid_i && fault_i, (fault_state_i != 3'd0) && (fault_state_i <= 3'd4) && (fault_event_i != 3'd0) && (fault_event_i != 3'd7))

  // Fault codes stay zero without a fault
  `NIFD_ASSERT_NOW(a_no_fault_zero, clk_i, rst_ni, out_valid_i && !fault_i, (fault_state_i == 3'd0) && (fault_event_i == 3'd0))

  // A fault restarts the frame: nothing ready, bytes cleared
  `NIFD_ASSERT_NOW(a_fault_restart, clk_i, rst_ni, out_valid_i && fault_i, !frame_ready_i && !is_repeat_i && (address_byte_i == 8'h00) && (command_byte_i == 8'h00))

  // A stalled result stays offered
  `NIFD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

endmodule

bind nec_ir_frame_decoder_top nifd_checker u_nifd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .frame_ready_i  (out_o.frame_ready),
  .address_byte_i (out_o.address_byte),
  .command_byte_i (out_o.command_byte),
  .is_repeat_i    (out_o.is_repeat),
  .fault_i        (out_o.fault),
  .fault_state_i  (out_o.fault_state),
  .fault_event_i  (out_o.fault_event)
);

`default_nettype wire

/* tb/nifd_frame_checker.sv */
// Scoreboard for the NEC IR frame decoder: tracks window writes, predicts one status per request.
// Compares every accepted result with the oldest prediction.
// Depends on nifd_pkg and the nifd_in_if / nifd_out_if interfaces.
`default_nettype none

module nifd_frame_checker
  import nifd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WIN_W-1:0]     cfg_wdata_i,
  nifd_in_if                   req_i,
  nifd_out_if                  res_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       frame_ready;
    logic [7:0] address_byte;
    logic [7:0] command_byte;
    logic       is_repeat;
    logic       fault;
    logic [2:0] fault_state;
    logic [2:0] fault_event;
  } frame_status_t;

  // Window copies and decoder state
  logic [WIN_W-1:0] windows [NUM_WIN];
  phase_e           ph;
  logic             held_ready;
  logic             from_repeat;
  logic [7:0]       addr_q;
  logic [7:0]       cmd_q;
  logic [7:0]       prior_addr;
  logic [7:0]       prior_cmd;
  logic [4:0]       edge_cnt;
  logic [7:0]       shift_q;
  logic             inverse_half;
  logic             on_command;

  // Error seen by the request being decoded
  logic             fault_hit;
  phase_e           fault_ph;
  event_e           fault_ev;

  frame_status_t    expected_status [$];

  function automatic logic in_window(logic [WIN_W-1:0] w, logic [15:0] t);
    return (t >= w[15:0]) && (t <= w[31:16]);
  endfunction

  // Drop the frame: keep its bytes as the prior frame, then clear them
  function automatic void restart_frame();
    ph          = PH_IDLE;
    held_ready  = 1'b0;
    from_repeat = 1'b0;
    prior_addr  = addr_q;
    prior_cmd   = cmd_q;
    addr_q      = '0;
    cmd_q       = '0;
  endfunction

  function automatic void raise_fault(event_e ev);
    fault_hit = 1'b1;
    fault_ph  = ph;
    fault_ev  = ev;
    restart_frame();
  endfunction

  // Shift one data bit in; only long and short spaces are legal bits
  function automatic logic shift_space(event_e ev);
    shift_q = {shift_q[6:0], ev == EV_LONG};
    return (ev == EV_LONG) || (ev == EV_SHORT);
  endfunction

  function automatic frame_status_t decode_request(op_e op, logic [15:0] ticks);
    event_e        ev;
    logic [7:0]    held;
    frame_status_t st;
    fault_hit = 1'b0;
    fault_ph  = PH_IDLE;
    fault_ev  = EV_IDLE;
    if (op == OP_RELEASE) begin
      restart_frame();
    end else if (!held_ready) begin
      // Sort the interval into the first window that holds it; idle gives the idle event
      if (ph == PH_IDLE) ev = EV_IDLE;
      else if (in_window(windows[REG_LEADER], ticks)) ev = EV_LEADER;
      else if (in_window(windows[REG_FRAME], ticks)) ev = EV_FRAME;
      else if (in_window(windows[REG_REPEAT], ticks)) ev = EV_REPEAT;
      else if (in_window(windows[REG_ONE], ticks)) ev = EV_LONG;
      else if (in_window(windows[REG_SHORT], ticks)) ev = EV_SHORT;
      else ev = EV_UNKNOWN;

      if (ph == PH_IDLE) begin
        ph = PH_LEADER;
      end else if (ph == PH_LEADER && ev == EV_LEADER) begin
        ph = PH_SPACE;
      end else if (ph == PH_SPACE && ev == EV_FRAME) begin
        ph           = PH_DATA;
        on_command   = 1'b0;
        inverse_half = 1'b0;
        edge_cnt     = '0;
        shift_q      = '0;
      end else if (ph == PH_SPACE && ev == EV_REPEAT) begin
        ph          = PH_END;
        addr_q      = prior_addr;
        cmd_q       = prior_cmd;
        from_repeat = 1'b1;
      end else if (ph == PH_DATA) begin
        edge_cnt = edge_cnt + 5'd1;
        if (edge_cnt >= EDGES_PER_BYTE) begin
          // Last bit of a byte: store it, or check it against its inverse
          if (!shift_space(ev)) begin
            raise_fault(ev);
          end else if (!inverse_half) begin
            inverse_half = 1'b1;
            if (on_command) cmd_q = shift_q;
            else addr_q = shift_q;
          end else begin
            held = on_command ? cmd_q : addr_q;
            if ((held & shift_q) == 8'h00) begin
              inverse_half = 1'b0;
              if (!on_command) on_command = 1'b1;
              else ph = PH_END;
            end else begin
              raise_fault(ev);
            end
          end
          edge_cnt = '0;
          shift_q  = '0;
        end else if (!edge_cnt[0]) begin
          if (!shift_space(ev)) raise_fault(ev);
        end
      end else if (ph == PH_END && ev == EV_SHORT) begin
        held_ready = 1'b1;
      end else begin
        raise_fault(ev);
      end
    end
    st.frame_ready  = held_ready;
    st.address_byte = addr_q;
    st.command_byte = cmd_q;
    st.is_repeat    = from_repeat;
    st.fault        = fault_hit;
    st.fault_state  = fault_hit ? fault_ph : PH_IDLE;
    st.fault_event  = fault_hit ? fault_ev : EV_IDLE;
    return st;
  endfunction

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    frame_status_t got;
    frame_status_t want;
    if (!rst_ni) begin
      windows[REG_LEADER] = RST_LEADER;
      windows[REG_FRAME]  = RST_FRAME;
      windows[REG_REPEAT] = RST_REPEAT;
      windows[REG_ONE]    = RST_ONE;
      windows[REG_SHORT]  = RST_SHORT;
      ph           = PH_IDLE;
      held_ready   = 1'b0;
      from_repeat  = 1'b0;
      addr_q       = '0;
      cmd_q        = '0;
      prior_addr   = '0;
      prior_cmd    = '0;
      edge_cnt     = '0;
      shift_q      = '0;
      inverse_half = 1'b0;
      on_command   = 1'b0;
      expected_status.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i && cfg_idx_i < NUM_WIN) windows[cfg_idx_i] = cfg_wdata_i;

      if (req_i.valid && req_i.ready)
        expected_status.push_back(decode_request(op_e'(req_i.operation), req_i.interval));

      if (res_i.valid && res_i.ready) begin
        got = '{res_i.frame_ready, res_i.address_byte, res_i.command_byte, res_i.is_repeat,
                res_i.fault, res_i.fault_state, res_i.fault_event};
        if (expected_status.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with no request pending: expected none, got %h",
                   $time, got);
        end else begin
          want = expected_status.pop_front();
          if (got !== want) begin
            fail_count_o++;
            $display({"%0t: status mismatch: expected rdy=%0b addr=%02h cmd=%02h ",
                      "rpt=%0b flt=%0b st=%0d ev=%0d, got rdy=%0b addr=%02h ",
                      "cmd=%02h rpt=%0b flt=%0b st=%0d ev=%0d"},
                     $time, want.frame_ready, want.address_byte, want.command_byte,
                     want.is_repeat, want.fault, want.fault_state, want.fault_event,
                     got.frame_ready, got.address_byte, got.command_byte,
                     got.is_repeat, got.fault, got.fault_state, got.fault_event);
          end
        end
      end
      pending_o = expected_status.size();
    end
  end

endmodule

`default_nettype wire

/* tb/tb_nec_ir_frame_decoder_top.sv */
// Testbench top for the NEC IR frame decoder: drives edge and release requests,
// window writes and result backpressure, and gives the verdict.
// Depends on nifd_pkg, the nifd interfaces, nec_ir_frame_decoder_top and nifd_frame_checker.
`default_nettype none

module tb_nec_ir_frame_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nifd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 200;

  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [WIN_W-1:0]     cfg_wdata_i;

  nifd_in_if  req_if ();
  nifd_out_if res_if ();

  int unsigned fail_count;
  int unsigned pending;

  // Stimulus bookkeeping
  logic [WIN_W-1:0] win_cfg [NUM_WIN];
  int               burst_left;
  int unsigned      items_sent;
  int unsigned      hold_requests;
  int unsigned      quiet_cycles;

  always #2 clk_i = ~clk_i;

  nec_ir_frame_decoder_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (res_if)
  );

  nifd_frame_checker status_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_i        (req_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Interval inside a window, or anything when the window is empty
  function automatic logic [15:0] pick_ticks(logic [CFG_IDX_W-1:0] idx);
    logic [15:0] lo;
    logic [15:0] hi;
    lo = win_cfg[idx][15:0];
    hi = win_cfg[idx][31:16];
    if (lo > hi) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(hi, lo));
  endfunction

  // Offer one request in bursts with random gaps; return at the falling edge after acceptance
  task automatic send_request(op_e op, logic [15:0] ticks);
    if (burst_left <= 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 10);
    end
    req_if.valid     = 1'b1;
    req_if.operation = op;
    req_if.interval  = ticks;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // Edge that now and then turns into line noise or a stray release
  task automatic send_tick(logic [15:0] ticks);
    int unsigned roll;
    roll = $urandom_range(0, 399);
    if (roll == 0) send_request(OP_RELEASE, 16'($urandom()));
    else if (roll < 3) send_request(OP_EDGE, 16'($urandom()));
    else send_request(OP_EDGE, ticks);
  endtask

  // One full frame or repeat code with random content, then release
  task automatic send_frame(bit as_repeat);
    logic [7:0] payload [4];
    payload[0] = 8'($urandom());
    payload[1] = ~payload[0];
    payload[2] = 8'($urandom());
    payload[3] = ~payload[2];
    // spoil an inverse byte at times; many spoiled values still pass the AND check
    if ($urandom_range(0, 5) == 0) payload[1] = 8'($urandom());
    if ($urandom_range(0, 5) == 0) payload[3] = 8'($urandom());
    send_request(OP_EDGE, 16'($urandom()));
    send_tick(pick_ticks(REG_LEADER));
    if (as_repeat) begin
      send_tick(pick_ticks(REG_REPEAT));
    end else begin
      send_tick(pick_ticks(REG_FRAME));
      for (int k = 0; k < 4; k++) begin
        for (int b = 7; b >= 0; b--) begin
          send_tick(pick_ticks(REG_SHORT));
          send_tick(payload[k][b] ? pick_ticks(REG_ONE) : pick_ticks(REG_SHORT));
        end
      end
    end
    send_tick(pick_ticks(REG_SHORT));
    // edges that arrive while the frame is held
    repeat ($urandom_range(0, 2)) send_request(OP_EDGE, 16'($urandom()));
    send_request(OP_RELEASE, 16'($urandom()));
  endtask

  task automatic run_random(int unsigned budget);
    int unsigned stop_at;
    int unsigned roll;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 9);
      if (roll < 4) begin
        send_frame(1'b0);
      end else if (roll < 8) begin
        send_frame(1'b1);
      end else begin
        repeat ($urandom_range(1, 6))
          send_request(($urandom_range(0, 3) == 0) ? OP_RELEASE : OP_EDGE,
                       ($urandom_range(0, 1) == 0) ? 16'($urandom()) :
                       pick_ticks(CFG_IDX_W'($urandom_range(0, NUM_WIN - 1))));
      end
    end
  endtask

  // Drain the block, then rewrite all five windows
  task automatic program_windows(logic [WIN_W-1:0] w_leader, logic [WIN_W-1:0] w_frame,
                                 logic [WIN_W-1:0] w_repeat, logic [WIN_W-1:0] w_one,
                                 logic [WIN_W-1:0] w_short);
    logic [WIN_W-1:0] vals [NUM_WIN];
    vals[REG_LEADER] = w_leader;
    vals[REG_FRAME]  = w_frame;
    vals[REG_REPEAT] = w_repeat;
    vals[REG_ONE]    = w_one;
    vals[REG_SHORT]  = w_short;
    req_if.valid = 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
    for (int i = 0; i < NUM_WIN; i++) begin
      cfg_we_i    = 1'b1;
      cfg_idx_i   = CFG_IDX_W'(i);
      cfg_wdata_i = vals[i];
      win_cfg[i]  = vals[i];
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
  endtask

  // Main stimulus
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = REG_LEADER;
    cfg_wdata_i      = '0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_EDGE;
    req_if.interval  = '0;
    win_cfg[REG_LEADER] = RST_LEADER;
    win_cfg[REG_FRAME]  = RST_FRAME;
    win_cfg[REG_REPEAT] = RST_REPEAT;
    win_cfg[REG_ONE]    = RST_ONE;
    win_cfg[REG_SHORT]  = RST_SHORT;
    burst_left    = 0;
    items_sent    = 0;
    hold_requests = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed requests on the reset windows
    send_request(OP_RELEASE, 16'h0000);   // release with nothing held
    send_request(OP_EDGE, 16'h0000);      // idle edge starts a frame
    send_request(OP_EDGE, 16'hFFFF);      // unknown interval in leader
    send_request(OP_EDGE, 16'hFFFF);
    send_request(OP_EDGE, 16'd9000);
    send_request(OP_EDGE, 16'd2250);      // repeat reloads the prior frame
    send_request(OP_EDGE, 16'h5555);      // unknown interval in end
    send_request(OP_EDGE, 16'd9000);
    send_request(OP_EDGE, 16'd4500);      // command space in leader
    send_request(OP_EDGE, 16'd560);
    send_request(OP_EDGE, 16'd1690);      // one-bit space in leader
    send_request(OP_EDGE, 16'd9000);
    send_request(OP_EDGE, 16'd9000);      // leader space enters the space phase
    send_request(OP_EDGE, 16'hAAAA);
    send_request(OP_EDGE, 16'd9000);
    send_request(OP_EDGE, 16'd2250);
    send_request(OP_EDGE, 16'd4500);      // idle edge starts a frame
    send_request(OP_EDGE, 16'd1);
    send_request(OP_EDGE, 16'd9000);
    send_request(OP_EDGE, 16'd2250);
    send_request(OP_EDGE, 16'd560);       // idle edge starts a frame
    send_request(OP_EDGE, 16'd9000);      // leader space enters the space phase
    send_request(OP_RELEASE, 16'hFFFF);
    send_request(OP_EDGE, 16'd7);
    send_request(OP_EDGE, 16'd4500);      // command space in leader

    run_random(150);

    // Compact windows; hold off the result side while requests keep coming
    program_windows({16'd140, 16'd100}, {16'd70, 16'd50}, {16'd40, 16'd30},
                    {16'd28, 16'd20}, {16'd12, 16'd5});
    hold_requests++;
    run_random(150);

    // Full-range, single-value and empty windows
    program_windows({16'hFFFF, 16'h0000}, {16'h0000, 16'hFFFF}, 32'h0000_0000,
                    32'hFFFF_FFFF, {16'hFFFF, 16'h0000});
    run_random(70);
    program_windows({16'hFFFF, 16'hFFFF}, 32'h0000_0000, {16'h0002, 16'h0002},
                    {16'hFFFE, 16'h0003}, {16'h0001, 16'h0001});
    run_random(70);

    program_windows(RST_LEADER, RST_FRAME, RST_REPEAT, RST_ONE, RST_SHORT);
    run_random(150);

    // Drain and let any stray result show up
    req_if.valid = 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("nec_ir_frame_decoder_top: match");
    end else begin
      $display("nec_ir_frame_decoder_top: mismatch");
    end
    $finish;
  end

  // Result side: stall patterns that change over time, plus one long hold-off
  initial begin
    int unsigned hold_left;
    int unsigned holds_done;
    int unsigned mode_left;
    rx_mode_e    mode;
    res_if.ready = 1'b0;
    hold_left    = 0;
    holds_done   = 0;
    mode_left    = 0;
    mode         = RX_STREAM;
    forever begin
      @(negedge clk_i);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left  = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 120);
        end
        mode_left--;
        case (mode)
          RX_STREAM: res_if.ready = 1'b1;
          RX_COIN:   res_if.ready = 1'($urandom_range(0, 1));
          RX_SPARSE: res_if.ready = ($urandom_range(0, 4) == 0);
          default:   res_if.ready = (mode_left % 3 != 0);
        endcase
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("nec_ir_frame_decoder_top: mismatch");
      $finish;
    end
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/nifd_pkg.sv
rtl/nifd_if.sv
rtl/nifd_front.sv
rtl/nifd_queue.sv
rtl/nifd_back.sv
rtl/nec_ir_frame_decoder_top.sv
rtl/nifd_checker.sv
tb/nifd_frame_checker.sv
tb/tb_nec_ir_frame_decoder_top.sv
